// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BLOCKS_D  = 1024;
  localparam int BLOCK_BYTES_D = 64;

  // used-map memory word
  localparam int MAP_W   = 32;
  localparam int MAP_SH  = 5;

  // fixed field widths
  localparam int BYTES_W = 17;
  localparam int PBLK_W  = 11;
  localparam int ADDR_W  = 32;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic CFG_POOL_BASE   = 1'b0;
  localparam logic CFG_POOL_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOGAP   = 2'd2
  } status_t;

endpackage

// ===== hdl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ffba_div.sv =====
// ----------------------------------------------------------------------------
// ffba_div
// Quotient by the block size, a power of two: one registered shift, with done
// raised in the cycle after start.
// ----------------------------------------------------------------------------
module ffba_div #(
  parameter int DIVISOR = ffba_pkg::BLOCK_BYTES_D,
  parameter int NUM_W   = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int SH = $clog2(DIVISOR);

  logic [NUM_W-1:0] quo_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
      // hold the quotient until the next start
      if (start) begin
        quo_r <= num >> SH;
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hdl/ffba_wsrch.sv =====
// ----------------------------------------------------------------------------
// ffba_wsrch
// Free-run search over one used-map word, carrying the run from the word below.
// ----------------------------------------------------------------------------
module ffba_wsrch #(
  parameter int BN_W = 12
) (
  input  logic [ffba_pkg::MAP_W-1:0]  free_bits,
  input  logic [BN_W-1:0]             carry_in,
  input  logic [BN_W-1:0]             need,
  output logic                        hit,
  output logic [ffba_pkg::MAP_SH-1:0] pos,
  output logic [BN_W-1:0]             carry_out
);

  import ffba_pkg::*;

  localparam int L_W = MAP_SH + 1;

  logic [L_W-1:0]  run_len [MAP_SH+1][MAP_W];
  logic [BN_W-1:0] total [MAP_W];
  logic [MAP_W-1:0] hits;

  // run length ending at each bit, doubling the window each level
  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      run_len[0][j] = L_W'(free_bits[j]);
    end
    for (int s = 0; s < MAP_SH; s++) begin
      for (int j = 0; j < MAP_W; j++) begin
        if (j >= (1 << s) && run_len[s][j] == L_W'(1 << s)) begin
          run_len[s+1][j] = L_W'(1 << s) + run_len[s][j - (1 << s)];
        end else begin
          run_len[s+1][j] = run_len[s][j];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      if (run_len[MAP_SH][j] == L_W'(j + 1)) begin
        total[j] = carry_in + BN_W'(j + 1);
      end else begin
        total[j] = BN_W'(run_len[MAP_SH][j]);
      end
      hits[j] = free_bits[j] && (total[j] == need);
    end
  end

  always_comb begin
    pos = '0;
    for (int j = MAP_W - 1; j >= 0; j--) begin
      if (hits[j]) begin
        pos = MAP_SH'(j);
      end
    end
  end

  assign hit       = |hits;
  assign carry_out = total[MAP_W-1];

endmodule

// ===== hdl/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over a pool of fixed-size blocks kept in a used-map RAM
// and a run-length RAM.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    func, req_bytes, addr
//   out_     output     out_valid / out_ready  status, result_addr, byte counts, op counts
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// One item at a time. The word is taken in S_IDLE, the quotient comes from the
// registered shift by the block size (S_DIV), then come the range checks (S_CHK).
// An allocate scans the used map one 32-bit word per cycle, then reads the first
// word it covers (S_MRD) and rewrites the words it covers in turn (S_MWR). A free
// reads the run length and clears its words the same way; a request rejected on
// arrival goes straight to S_DONE. After reset and after every config write a
// clearing pass over both memories runs before the next input word is taken;
// a config write waits while an item is in flight. A stalled result waits in the
// output register while the next item runs; a second result holds until it drains.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
  parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_D,
  parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [ffba_pkg::ADDR_W-1:0]  in_req_bytes,
  input  logic [ffba_pkg::ADDR_W-1:0]  in_addr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [ffba_pkg::ADDR_W-1:0]  out_result_addr,
  output logic [ffba_pkg::BYTES_W-1:0] out_free_bytes,
  output logic [ffba_pkg::BYTES_W-1:0] out_min_free_bytes,
  output logic [31:0]                  out_alloc_count,
  output logic [31:0]                  out_free_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_wdata
);

  import ffba_pkg::*;

  localparam int WORDS  = (NUM_BLOCKS + MAP_W - 1) / MAP_W;
  localparam int WA_W   = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int IDX_W  = WA_W + MAP_SH;
  localparam int BN_W   = IDX_W + 1;
  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int FB_RAW = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
  localparam int FB_W   = FB_RAW > BYTES_W ? FB_RAW : BYTES_W;
  localparam int Q_W    = ADDR_W + 1;

  localparam logic [BN_W-1:0] NB       = BN_W'(NUM_BLOCKS);
  localparam logic [WA_W-1:0] LAST_WRD = WA_W'(WORDS - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_CHK, S_SCAN, S_MRD, S_MWR, S_RLEN, S_DONE
  } state_t;

  state_t            state_r;
  logic [BN_W-1:0]   clr_r;
  logic [ADDR_W-1:0] base_r;
  logic [PBLK_W-1:0] pblocks_r;
  logic              func_r;
  status_t           status_r;
  logic [BN_W-1:0]   need_r;
  logic [BN_W-1:0]   blk_r;
  logic [BN_W-1:0]   ms_r;
  logic [BN_W-1:0]   me_r;
  logic [WA_W-1:0]   mw_r;
  logic [WA_W-1:0]   ew_r;
  logic              setv_r;
  logic [WA_W-1:0]   scan_w_r;
  logic [BN_W-1:0]   carry_r;
  logic [FB_W-1:0]   prod_r;
  logic [ADDR_W-1:0] amul_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [FB_W-1:0]   free_cnt_r;
  logic [FB_W-1:0]   low_r;
  logic [31:0]       alloc_tot_r;
  logic [31:0]       free_tot_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [FB_W-1:0]   out_free_r;
  logic [FB_W-1:0]   out_low_r;
  logic [31:0]       out_alloc_r;
  logic [31:0]       out_freec_r;

  // effective block count and free bytes of an empty pool
  logic [BN_W-1:0] eff;
  logic [FB_W-1:0] fb_init;

  always_comb begin
    if (pblocks_r < PBLK_W'(2)) begin
      eff = BN_W'(2);
    end else if (32'(pblocks_r) > 32'(NUM_BLOCKS)) begin
      eff = NB;
    end else begin
      eff = BN_W'(pblocks_r);
    end
  end

  assign fb_init = FB_W'(32'(eff - 1'b1) * BLOCK_BYTES);

  // divider
  logic           div_start;
  logic [Q_W-1:0] div_num;
  logic           div_done;
  logic [Q_W-1:0] quot;
  logic           req_bad;

  always_comb begin
    if (in_func == FUNC_ALLOC) begin
      req_bad = (in_req_bytes == '0);
      div_num = {1'b0, in_req_bytes} + Q_W'(BLOCK_BYTES - 1);
    end else begin
      req_bad = (in_addr == '0) || (in_addr < base_r);
      div_num = {1'b0, in_addr - base_r};
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  // take a config word only between items
  assign cfg_ready = (state_r == S_CLR) || (state_r == S_IDLE && !in_valid);
  assign div_start = in_valid && in_ready && !req_bad;

  ffba_div #(.DIVISOR(BLOCK_BYTES), .NUM_W(Q_W)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .done (div_done),
    .quot (quot)
  );

  // memories
  logic             u_we;
  logic [WA_W-1:0]  u_waddr;
  logic [MAP_W-1:0] u_wdata;
  logic [WA_W-1:0]  u_raddr;
  logic [MAP_W-1:0] u_rdata;
  logic             r_we;
  logic [BLK_W-1:0] r_waddr;
  logic [BN_W-1:0]  r_wdata;
  logic [BLK_W-1:0] r_raddr;
  logic [BN_W-1:0]  r_rdata;

  ffba_ram #(.WIDTH(MAP_W), .DEPTH(WORDS)) u_used_ram (
    .clk  (clk),
    .we   (u_we),
    .waddr(u_waddr),
    .wdata(u_wdata),
    .raddr(u_raddr),
    .rdata(u_rdata)
  );

  ffba_ram #(.WIDTH(BN_W), .DEPTH(NUM_BLOCKS)) u_run_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .raddr(r_raddr),
    .rdata(r_rdata)
  );

  // word search
  logic [MAP_W-1:0]  free_bits;
  logic              s_hit;
  logic [MAP_SH-1:0] s_pos;
  logic [BN_W-1:0]   s_carry;
  logic [IDX_W-1:0]  hit_blk;
  logic [BN_W-1:0]   hit_start;

  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      free_bits[j] = !u_rdata[j] && ({scan_w_r, MAP_SH'(j)} != '0)
                     && (BN_W'({scan_w_r, MAP_SH'(j)}) < eff);
    end
  end

  ffba_wsrch #(.BN_W(BN_W)) u_wsrch (
    .free_bits(free_bits),
    .carry_in (carry_r),
    .need     (need_r),
    .hit      (s_hit),
    .pos      (s_pos),
    .carry_out(s_carry)
  );

  assign hit_blk   = {scan_w_r, s_pos};
  assign hit_start = BN_W'(hit_blk) + 1'b1 - need_r;

  // mark / clear mask for the word under rewrite
  logic [MAP_W-1:0] mark_mask;
  logic [MAP_W-1:0] mark_word;

  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      mark_mask[j] = (BN_W'({mw_r, MAP_SH'(j)}) >= ms_r)
                     && (BN_W'({mw_r, MAP_SH'(j)}) <= me_r);
    end
    mark_word = setv_r ? (u_rdata | mark_mask) : (u_rdata & ~mark_mask);
  end

  // end of a freed run, clamped to the pool
  logic [BN_W:0]   run_end;
  logic [BN_W-1:0] free_last;

  always_comb begin
    run_end = {1'b0, blk_r} + {1'b0, r_rdata};
    if (run_end > {1'b0, eff}) begin
      free_last = eff - 1'b1;
    end else begin
      free_last = BN_W'(run_end - 1'b1);
    end
  end

  // stats after a successful operation
  logic [FB_W-1:0] free_upd;

  assign free_upd = (func_r == FUNC_ALLOC) ? free_cnt_r - prod_r : free_cnt_r + prod_r;

  // memory port control
  always_comb begin
    u_we    = 1'b0;
    u_waddr = mw_r;
    u_wdata = mark_word;
    u_raddr = scan_w_r;
    r_we    = 1'b0;
    r_waddr = ms_r[BLK_W-1:0];
    r_wdata = need_r;
    r_raddr = quot[BLK_W-1:0];
    case (state_r)
      S_CLR: begin
        u_we    = (clr_r < BN_W'(WORDS));
        u_waddr = clr_r[WA_W-1:0];
        u_wdata = MAP_W'(clr_r == '0);
        r_we    = 1'b1;
        r_waddr = clr_r[BLK_W-1:0];
        r_wdata = BN_W'(clr_r == '0);
      end
      S_CHK:  u_raddr = '0;
      S_SCAN: u_raddr = scan_w_r + 1'b1;
      S_MRD: begin
        u_raddr = mw_r;
        r_we    = (func_r == FUNC_ALLOC);
      end
      S_MWR: begin
        u_we    = 1'b1;
        u_raddr = mw_r + 1'b1;
      end
      S_RLEN: begin
        r_we    = (r_rdata != '0);
        r_waddr = blk_r[BLK_W-1:0];
        r_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      base_r      <= '0;
      pblocks_r   <= PBLK_W'(1024);
      alloc_tot_r <= '0;
      free_tot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        // pool setup: reload registers and sweep the memories again
        case (cfg_index)
          CFG_POOL_BASE:   base_r    <= cfg_wdata;
          CFG_POOL_BLOCKS: pblocks_r <= cfg_wdata[PBLK_W-1:0];
          default: ;
        endcase
        alloc_tot_r <= '0;
        free_tot_r  <= '0;
        clr_r       <= '0;
        state_r     <= S_CLR;
      end else begin
        case (state_r)
          S_CLR: begin
            clr_r <= clr_r + 1'b1;
            if (clr_r == NB - 1'b1) begin
              free_cnt_r <= fb_init;
              low_r      <= fb_init;
              state_r    <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (in_valid) begin
              func_r     <= in_func;
              res_addr_r <= '0;
              if (req_bad) begin
                status_r <= ST_INVALID;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_DIV;
              end
            end
          end

          S_DIV: begin
            if (div_done) begin
              state_r <= S_CHK;
            end
          end

          S_CHK: begin
            if (func_r == FUNC_ALLOC) begin
              if (quot > Q_W'(eff - 1'b1)) begin
                status_r <= ST_NOGAP;
                state_r  <= S_DONE;
              end else begin
                need_r   <= quot[BN_W-1:0];
                prod_r   <= FB_W'(32'(quot[BN_W-1:0]) * BLOCK_BYTES);
                scan_w_r <= '0;
                carry_r  <= '0;
                state_r  <= S_SCAN;
              end
            end else begin
              if (quot == '0 || quot >= Q_W'(eff)) begin
                status_r <= ST_INVALID;
                state_r  <= S_DONE;
              end else begin
                blk_r   <= quot[BN_W-1:0];
                state_r <= S_RLEN;
              end
            end
          end

          S_SCAN: begin
            if (s_hit) begin
              ms_r    <= hit_start;
              me_r    <= BN_W'(hit_blk);
              mw_r    <= hit_start[IDX_W-1:MAP_SH];
              ew_r    <= scan_w_r;
              setv_r  <= 1'b1;
              state_r <= S_MRD;
            end else if (scan_w_r == LAST_WRD) begin
              status_r <= ST_NOGAP;
              state_r  <= S_DONE;
            end else begin
              scan_w_r <= scan_w_r + 1'b1;
              carry_r  <= s_carry;
            end
          end

          S_RLEN: begin
            if (r_rdata == '0) begin
              status_r <= ST_INVALID;
              state_r  <= S_DONE;
            end else begin
              ms_r    <= blk_r;
              me_r    <= free_last;
              mw_r    <= blk_r[IDX_W-1:MAP_SH];
              ew_r    <= free_last[IDX_W-1:MAP_SH];
              setv_r  <= 1'b0;
              prod_r  <= FB_W'(32'(r_rdata) * BLOCK_BYTES);
              state_r <= S_MRD;
            end
          end

          S_MRD: begin
            amul_r  <= ADDR_W'(32'(ms_r) * BLOCK_BYTES);
            state_r <= S_MWR;
          end

          S_MWR: begin
            if (mw_r == ew_r) begin
              // last word written: commit the counters
              status_r   <= ST_OK;
              free_cnt_r <= free_upd;
              if (func_r == FUNC_ALLOC) begin
                alloc_tot_r <= alloc_tot_r + 1'b1;
                res_addr_r  <= base_r + amul_r;
                if (free_upd < low_r) begin
                  low_r <= free_upd;
                end
              end else begin
                free_tot_r <= free_tot_r + 1'b1;
              end
              state_r <= S_DONE;
            end else begin
              mw_r <= mw_r + 1'b1;
            end
          end

          S_DONE: begin
            if (!out_valid_r || out_ready) begin
              out_valid_r  <= 1'b1;
              out_status_r <= status_r;
              out_addr_r   <= res_addr_r;
              out_free_r   <= free_cnt_r;
              out_low_r    <= low_r;
              out_alloc_r  <= alloc_tot_r;
              out_freec_r  <= free_tot_r;
              state_r      <= S_IDLE;
            end
          end

          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_addr    = out_addr_r;
  assign out_free_bytes     = out_free_r[BYTES_W-1:0];
  assign out_min_free_bytes = out_low_r[BYTES_W-1:0];
  assign out_alloc_count    = out_alloc_r;
  assign out_free_count     = out_freec_r;

  a_low_below_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (low_r <= free_cnt_r && free_cnt_r <= fb_init))
    else $error("low-water mark or free count out of range");

  a_mark_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR) |-> (mw_r <= ew_r))
    else $error("word rewrite ran past its last word");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the done state");

  a_scan_need: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (need_r != '0 && need_r < eff))
    else $error("scan started with an impossible block count");

endmodule

// ===== test/tb_first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_top
// Self-checking bench for the first-fit block allocator: a behavioral pool
// model predicts every result word, directed and random allocate/free traffic
// runs under several pool setups with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_top;
  import ffba_pkg::*;

  localparam int NBLK = NUM_BLOCKS_D;
  localparam int BSZ  = BLOCK_BYTES_D;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   result_addr;
    logic [BYTES_W-1:0]  free_bytes;
    logic [BYTES_W-1:0]  min_free_bytes;
    logic [31:0]         alloc_count;
    logic [31:0]         free_count;
  } alloc_result_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_func;
  logic [ADDR_W-1:0] in_req_bytes, in_addr;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [ADDR_W-1:0] out_result_addr;
  logic [BYTES_W-1:0] out_free_bytes, out_min_free_bytes;
  logic [31:0] out_alloc_count, out_free_count;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_wdata;

  first_fit_block_allocator_top DUT (.*);

  // pool model
  logic [31:0] mdl_base;
  logic [10:0] mdl_blocks_reg;
  int unsigned mdl_run_len [NBLK];
  bit          mdl_used    [NBLK];
  longint unsigned mdl_free_bytes, mdl_low_water;
  logic [31:0] mdl_alloc_total, mdl_free_total;

  alloc_result_t pending_results[$];
  int unsigned   mismatch_count;
  bit            no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pool_span();
    int unsigned p;
    p = mdl_blocks_reg;
    if (p < 2) p = 2;
    if (p > NBLK) p = NBLK;
    return p;
  endfunction

  function automatic void pool_setup();
    for (int i = 0; i < NBLK; i++) begin
      mdl_run_len[i] = 0;
      mdl_used[i] = 1'b0;
    end
    mdl_run_len[0] = 1;
    mdl_used[0] = 1'b1;
    mdl_free_bytes = longint'(pool_span() - 1) * BSZ;
    mdl_low_water = mdl_free_bytes;
    mdl_alloc_total = '0;
    mdl_free_total = '0;
  endfunction

  function automatic status_t pool_alloc(logic [31:0] nbytes, output logic [31:0] ra);
    longint unsigned need;
    int unsigned p, run, start;
    p = pool_span();
    run = 0;
    start = 0;
    ra = '0;
    if (nbytes == 0) return ST_INVALID;
    need = (longint'(nbytes) + BSZ - 1) / BSZ;
    if (need > p - 1) return ST_NOGAP;
    for (int b = 1; b < p; b++) begin
      if (mdl_used[b]) begin
        run = 0;
        continue;
      end
      if (run == 0) start = b;
      run++;
      if (run == need) begin
        for (int k = start; k < start + run; k++) mdl_used[k] = 1'b1;
        mdl_run_len[start] = run;
        mdl_free_bytes -= need * BSZ;
        if (mdl_free_bytes < mdl_low_water) mdl_low_water = mdl_free_bytes;
        mdl_alloc_total++;
        ra = mdl_base + start * BSZ;
        return ST_OK;
      end
    end
    return ST_NOGAP;
  endfunction

  function automatic status_t pool_release(logic [31:0] a);
    logic [31:0] blk;
    int unsigned p, len;
    p = pool_span();
    if (a == 0 || a < mdl_base) return ST_INVALID;
    blk = (a - mdl_base) / BSZ;
    if (blk == 0 || blk >= p) return ST_INVALID;
    len = mdl_run_len[blk];
    if (len == 0) return ST_INVALID;
    for (int k = blk; k < blk + len && k < p; k++) mdl_used[k] = 1'b0;
    mdl_run_len[blk] = 0;
    mdl_free_bytes += longint'(len) * BSZ;
    mdl_free_total++;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_result(logic f, logic [31:0] nbytes,
                                                   logic [31:0] a);
    alloc_result_t r;
    logic [31:0] ra;
    ra = '0;
    if (f == FUNC_ALLOC) r.status = pool_alloc(nbytes, ra);
    else r.status = pool_release(a);
    r.result_addr = ra;
    r.free_bytes = mdl_free_bytes[BYTES_W-1:0];
    r.min_free_bytes = mdl_low_water[BYTES_W-1:0];
    r.alloc_count = mdl_alloc_total;
    r.free_count = mdl_free_total;
    return r;
  endfunction

  // address inside some live allocation, or 0 if none
  function automatic logic [31:0] pick_live_addr();
    int unsigned p, s, b;
    p = pool_span();
    s = $urandom_range(1, p - 1);
    for (int i = 0; i < p - 1; i++) begin
      b = 1 + (s - 1 + i) % (p - 1);
      if (mdl_run_len[b] != 0)
        return mdl_base + b * BSZ + (($urandom_range(0, 3) == 0) ? $urandom_range(0, BSZ - 1) : 0);
    end
    return '0;
  endfunction

  task automatic send_word(logic f, logic [31:0] nbytes, logic [31:0] a);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      if (gap > 1) ;
      @(negedge clk);
    end
    in_func = f;
    in_req_bytes = nbytes;
    in_addr = a;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(f, nbytes, a));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POOL_BASE) mdl_base = val;
    else mdl_blocks_reg = val[10:0];
    pool_setup();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_word();
    logic [31:0] a, nbytes;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: nbytes = $urandom_range(1, 4 * BSZ);
        6, 7:             nbytes = $urandom_range(1, 32 * BSZ);
        8:                nbytes = $urandom_range(1, pool_span() * BSZ);
        default:          nbytes = $urandom;
      endcase
      send_word(FUNC_ALLOC, nbytes, $urandom);
    end else begin
      a = (sel < 90) ? pick_live_addr() : 32'h0;
      if (a == 0) begin
        if ($urandom_range(0, 1)) a = $urandom;
        else a = mdl_base + $urandom_range(0, pool_span() + 2) * BSZ + $urandom_range(0, BSZ - 1);
      end
      send_word(FUNC_FREE, $urandom, a);
    end
  endtask

  task automatic test_directed_default();
    logic [31:0] a;
    send_word(FUNC_ALLOC, 32'd0, 32'd0);            // zero-byte request
    send_word(FUNC_ALLOC, 32'd1, 32'hFFFF_FFFF);
    send_word(FUNC_ALLOC, BSZ, 32'd0);
    send_word(FUNC_ALLOC, BSZ + 1, 32'd0);
    send_word(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);     // oversized
    send_word(FUNC_FREE, 32'hFFFF_FFFF, 32'd0);      // null address
    send_word(FUNC_FREE, 32'd0, 32'd5);              // sentinel block
    send_word(FUNC_FREE, 32'd0, NBLK * BSZ);         // past the pool
    send_word(FUNC_FREE, 32'd0, 32'hFFFF_FFFF);
    send_word(FUNC_FREE, 32'd0, 4 * BSZ);            // inside, not a start
    send_word(FUNC_FREE, 32'd0, 2 * BSZ + 17);       // unaligned start
    send_word(FUNC_FREE, 32'd0, 2 * BSZ);            // now freed already
    send_word(FUNC_ALLOC, (NBLK - 3) * BSZ, 32'd0);  // longer than any free run
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    a = pick_live_addr();
    send_word(FUNC_FREE, 32'd0, a);
  endtask

  task automatic test_small_pool();
    write_reg(CFG_POOL_BASE, 32'h1000_0000);
    write_reg(CFG_POOL_BLOCKS, 32'd2);
    send_word(FUNC_FREE, 32'd0, 32'h0000_0100);      // below the pool
    send_word(FUNC_ALLOC, BSZ, 32'd0);
    send_word(FUNC_ALLOC, 32'd1, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h1000_0000 + BSZ);
    write_reg(CFG_POOL_BLOCKS, 32'd0);               // clamps up
    send_word(FUNC_ALLOC, 2 * BSZ, 32'd0);
    write_reg(CFG_POOL_BLOCKS, 32'h7FF);             // clamps down
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFC0);         // result addresses wrap
    send_word(FUNC_ALLOC, 3 * BSZ, 32'd0);
    send_word(FUNC_FREE, 32'd0, 32'h0000_0000 + 0 * BSZ + 32'd1);
  endtask

  task automatic test_random_phase(logic [31:0] base, logic [31:0] nblocks, int n,
                                   bit drain_mid);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_BLOCKS, nblocks);
    for (int i = 0; i < n; i++) begin
      if (drain_mid && i == n / 2) wait_drained();
      random_word();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status || out_result_addr !== e.result_addr ||
            out_free_bytes !== e.free_bytes || out_min_free_bytes !== e.min_free_bytes ||
            out_alloc_count !== e.alloc_count || out_free_count !== e.free_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp st=%0d a=%h fb=%0d min=%0d ac=%0d fc=%0d got st=%0d a=%h fb=%0d min=%0d ac=%0d fc=%0d",
                     e.status, e.result_addr, e.free_bytes, e.min_free_bytes,
                     e.alloc_count, e.free_count, out_status, out_result_addr,
                     out_free_bytes, out_min_free_bytes, out_alloc_count, out_free_count);
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [31:0] rbase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ALLOC;
    in_req_bytes = '0;
    in_addr = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POOL_BASE;
    cfg_wdata = '0;
    mismatch_count = 0;
    no_idle = 1'b0;
    mdl_base = '0;
    mdl_blocks_reg = 11'd1024;
    pool_setup();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_default();
    test_small_pool();
    test_random_phase(32'h0, 32'd1024, 240, 1'b1);
    no_idle = 1'b1;
    test_random_phase(32'h8000_0000, 32'd64, 200, 1'b0);
    no_idle = 1'b0;
    rbase = $urandom;
    test_random_phase({rbase[31:6], 6'd0}, 32'd8, 200, 1'b0);
    test_random_phase(32'hFFFF_0000, 32'd300, 220, 1'b0);
    test_random_phase($urandom, $urandom_range(0, 2047), 220, 1'b0);

    wait_drained();
    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_div.sv
hdl/ffba_wsrch.sv
hdl/first_fit_block_allocator_top.sv
test/tb_first_fit_block_allocator_top.sv
